// ----- src/psmx_pkg.sv -----
`default_nettype none

package psmx_pkg;

   localparam int VALUE_W        = 43;
   localparam int MAX_ITEMS_DEF  = 1024;
   localparam int KEY_BITS_DEF   = 43;
   localparam int TRIE_NODES_DEF = 65536;

   typedef enum logic [3:0] {
      S_LOAD,
      S_INIT,
      S_INS_START,
      S_INS_WALK,
      S_INS_FRESH,
      S_Q_START,
      S_Q_WALK,
      S_Q_DONE,
      S_FETCH,
      S_FETCH_DATA,
      S_DONE
   } state_type;

endpackage

`default_nettype wire

// ----- src/psmx_if.sv -----
`default_nettype none

interface psmx_req_if;
   logic                        valid;
   logic                        ready;
   logic [psmx_pkg::VALUE_W-1:0] value;
   logic                        last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface

interface psmx_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [psmx_pkg::VALUE_W-1:0] max_xor;
   logic                        overflow;

   modport source (output valid, output max_xor, output overflow, input ready);
   modport sink   (input valid, input max_xor, input overflow, output ready);
endinterface

`default_nettype wire

// ----- src/prefix_suffix_max_xor.sv -----
`default_nettype none

// channel    role   payload                    transfer
// req_chan   sink   value[42:0], last          valid & ready
// rsp_chan   source max_xor[42:0], overflow    valid & ready
//
// Loading: one element per cycle; ready stays high while the block loads.
// Search: per split, one trie level per cycle for the insert and one for the query,
// all through the single trie memory.
// Reset clears the sequence counters; the memories need no clearing pass.
// A held result stalls only the end of the next search, not the loading.

module prefix_suffix_max_xor #(
   parameter int MAX_ITEMS  = psmx_pkg::MAX_ITEMS_DEF,
   parameter int KEY_BITS   = psmx_pkg::KEY_BITS_DEF,
   parameter int TRIE_NODES = psmx_pkg::TRIE_NODES_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   psmx_req_if.sink         req_chan,
   psmx_rsp_if.source       rsp_chan
);

   localparam int IDX_W  = $clog2(MAX_ITEMS + 1);
   localparam int NODE_W = $clog2(TRIE_NODES);
   localparam int NF_W   = $clog2(TRIE_NODES + 1);
   localparam int LVL_W  = (KEY_BITS > 1) ? $clog2(KEY_BITS) : 1;
   localparam int WORD_W = 2 * NODE_W;

   localparam logic [LVL_W-1:0]  LVL_TOP   = LVL_W'(KEY_BITS - 1);
   localparam logic [IDX_W-1:0]  IDX_MAX   = IDX_W'(MAX_ITEMS);
   localparam logic [NF_W-1:0]   NF_LIMIT  = NF_W'(TRIE_NODES);
   localparam logic [NODE_W-1:0] NODE_NONE = '0;

   logic [KEY_BITS-1:0] pstore_mem [MAX_ITEMS+1];
   logic [WORD_W-1:0]   trie_mem   [TRIE_NODES];

   psmx_pkg::state_type state_ff, state_in;
   logic [IDX_W-1:0]    count_ff, count_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [KEY_BITS-1:0] run_ff, run_in;
   logic                ovf_ff, ovf_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic [NODE_W-1:0]   cur_ff, cur_in;
   logic [LVL_W-1:0]    lvl_ff, lvl_in;
   logic                leaf_ff, leaf_in;
   logic [NF_W-1:0]     nf_ff, nf_in;
   logic [KEY_BITS-1:0] r_ff, r_in;
   logic [KEY_BITS-1:0] best_ff, best_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [psmx_pkg::VALUE_W-1:0] rsp_max_ff, rsp_max_in;
   logic                rsp_ovf_ff, rsp_ovf_in;

   logic [KEY_BITS-1:0] pstore_rd_ff;
   logic                pstore_we;
   logic [IDX_W-1:0]    pstore_waddr;
   logic [KEY_BITS-1:0] pstore_wdata;

   logic [WORD_W-1:0]   trie_rd_ff;
   logic                trie_we;
   logic [NODE_W-1:0]   trie_waddr;
   logic [WORD_W-1:0]   trie_wdata;
   logic [NODE_W-1:0]   trie_raddr;

   logic                in_xfer;
   logic [KEY_BITS-1:0] in_key;
   logic [KEY_BITS-1:0] run_next;
   logic [KEY_BITS-1:0] q_key;
   logic [NODE_W-1:0]   nf_node;
   logic                key_dir;
   logic                want_dir;
   logic [NODE_W-1:0]   child_dir;
   logic [NODE_W-1:0]   child_want;
   logic [NODE_W-1:0]   child_other;
   logic                nf_full;

   assign req_chan.ready    = (state_ff == psmx_pkg::S_LOAD);
   assign in_xfer           = req_chan.valid && req_chan.ready;
   assign in_key            = KEY_BITS'(req_chan.value);
   assign run_next          = run_ff ^ in_key;
   assign q_key             = run_ff ^ key_ff;
   assign nf_node           = nf_ff[NODE_W-1:0];
   assign nf_full           = (nf_ff >= NF_LIMIT);
   assign key_dir           = key_ff[lvl_ff];
   assign want_dir          = ~q_key[lvl_ff];
   assign child_dir         = key_dir  ? trie_rd_ff[WORD_W-1:NODE_W] : trie_rd_ff[NODE_W-1:0];
   assign child_want        = want_dir ? trie_rd_ff[WORD_W-1:NODE_W] : trie_rd_ff[NODE_W-1:0];
   assign child_other       = want_dir ? trie_rd_ff[NODE_W-1:0] : trie_rd_ff[WORD_W-1:NODE_W];

   assign rsp_chan.valid    = rsp_valid_ff;
   assign rsp_chan.max_xor  = rsp_max_ff;
   assign rsp_chan.overflow = rsp_ovf_ff;

   always_ff @(posedge clock) begin
      if (pstore_we) begin
         pstore_mem[pstore_waddr] <= pstore_wdata;
      end
      pstore_rd_ff <= pstore_mem[idx_ff];
   end

   always_ff @(posedge clock) begin
      if (trie_we) begin
         trie_mem[trie_waddr] <= trie_wdata;
      end
      trie_rd_ff <= trie_mem[trie_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= psmx_pkg::S_LOAD;
         count_ff     <= '0;
         run_ff       <= '0;
         ovf_ff       <= 1'b0;
         nf_ff        <= NF_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         run_ff       <= run_in;
         ovf_ff       <= ovf_in;
         nf_ff        <= nf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      idx_ff     <= idx_in;
      key_ff     <= key_in;
      cur_ff     <= cur_in;
      lvl_ff     <= lvl_in;
      leaf_ff    <= leaf_in;
      r_ff       <= r_in;
      best_ff    <= best_in;
      rsp_max_ff <= rsp_max_in;
      rsp_ovf_ff <= rsp_ovf_in;
   end

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      run_in       = run_ff;
      ovf_in       = ovf_ff;
      key_in       = key_ff;
      cur_in       = cur_ff;
      lvl_in       = lvl_ff;
      leaf_in      = leaf_ff;
      nf_in        = nf_ff;
      r_in         = r_ff;
      best_in      = best_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_max_in   = rsp_max_ff;
      rsp_ovf_in   = rsp_ovf_ff;
      pstore_we    = 1'b0;
      pstore_waddr = count_ff + IDX_W'(1);
      pstore_wdata = run_next;
      trie_we      = 1'b0;
      trie_waddr   = cur_ff;
      trie_wdata   = '0;
      trie_raddr   = NODE_NONE;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         psmx_pkg::S_LOAD: begin
            if (in_xfer) begin
               if (count_ff < IDX_MAX) begin
                  run_in    = run_next;
                  count_in  = count_ff + IDX_W'(1);
                  pstore_we = 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_chan.last) begin
                  state_in = psmx_pkg::S_INIT;
               end
            end
         end
         psmx_pkg::S_INIT: begin
            trie_we    = 1'b1;
            trie_waddr = NODE_NONE;
            nf_in      = NF_W'(1);
            best_in    = '0;
            key_in     = '0;
            idx_in     = '0;
            state_in   = psmx_pkg::S_INS_START;
         end
         psmx_pkg::S_INS_START: begin
            cur_in   = NODE_NONE;
            lvl_in   = LVL_TOP;
            leaf_in  = 1'b0;
            state_in = psmx_pkg::S_INS_WALK;
         end
         psmx_pkg::S_INS_WALK: begin
            if (child_dir != NODE_NONE) begin
               cur_in = child_dir;
               if (lvl_ff == '0) begin
                  state_in = psmx_pkg::S_Q_START;
               end else begin
                  lvl_in     = lvl_ff - LVL_W'(1);
                  trie_raddr = child_dir;
               end
            end else if (nf_full) begin
               state_in = psmx_pkg::S_Q_START;
            end else begin
               trie_we    = 1'b1;
               trie_wdata = key_dir ? {nf_node, trie_rd_ff[NODE_W-1:0]}
                                    : {trie_rd_ff[WORD_W-1:NODE_W], nf_node};
               cur_in     = nf_node;
               nf_in      = nf_ff + NF_W'(1);
               if (lvl_ff == '0) begin
                  leaf_in = 1'b1;
               end else begin
                  lvl_in = lvl_ff - LVL_W'(1);
               end
               state_in = psmx_pkg::S_INS_FRESH;
            end
         end
         psmx_pkg::S_INS_FRESH: begin
            trie_we = 1'b1;
            if (leaf_ff || nf_full) begin
               state_in = psmx_pkg::S_Q_START;
            end else begin
               trie_wdata = key_dir ? {nf_node, NODE_NONE} : {NODE_NONE, nf_node};
               cur_in     = nf_node;
               nf_in      = nf_ff + NF_W'(1);
               if (lvl_ff == '0) begin
                  leaf_in = 1'b1;
               end else begin
                  lvl_in = lvl_ff - LVL_W'(1);
               end
            end
         end
         psmx_pkg::S_Q_START: begin
            cur_in   = NODE_NONE;
            lvl_in   = LVL_TOP;
            r_in     = '0;
            state_in = psmx_pkg::S_Q_WALK;
         end
         psmx_pkg::S_Q_WALK: begin
            if (child_want != NODE_NONE) begin
               r_in[lvl_ff] = 1'b1;
               cur_in       = child_want;
               trie_raddr   = child_want;
               if (lvl_ff == '0) begin
                  state_in = psmx_pkg::S_Q_DONE;
               end else begin
                  lvl_in = lvl_ff - LVL_W'(1);
               end
            end else if (child_other != NODE_NONE) begin
               cur_in     = child_other;
               trie_raddr = child_other;
               if (lvl_ff == '0) begin
                  state_in = psmx_pkg::S_Q_DONE;
               end else begin
                  lvl_in = lvl_ff - LVL_W'(1);
               end
            end else begin
               state_in = psmx_pkg::S_Q_DONE;
            end
         end
         psmx_pkg::S_Q_DONE: begin
            if (r_ff > best_ff) begin
               best_in = r_ff;
            end
            if (idx_ff < count_ff) begin
               idx_in   = idx_ff + IDX_W'(1);
               state_in = psmx_pkg::S_FETCH;
            end else begin
               state_in = psmx_pkg::S_DONE;
            end
         end
         psmx_pkg::S_FETCH: begin
            state_in = psmx_pkg::S_FETCH_DATA;
         end
         psmx_pkg::S_FETCH_DATA: begin
            key_in   = pstore_rd_ff;
            state_in = psmx_pkg::S_INS_START;
         end
         psmx_pkg::S_DONE: begin
            if (!rsp_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_max_in   = psmx_pkg::VALUE_W'(best_ff);
               rsp_ovf_in   = ovf_ff;
               count_in     = '0;
               run_in       = '0;
               ovf_in       = 1'b0;
               state_in     = psmx_pkg::S_LOAD;
            end
         end
         default: begin
            state_in = psmx_pkg::S_LOAD;
         end
      endcase
   end

   a_nf_bound: assert property (@(posedge clock) disable iff (reset)
      nf_ff <= NF_LIMIT)
      else $error("trie allocation ran past the node limit");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= IDX_MAX)
      else $error("item count ran past the buffer size");

   a_query_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == psmx_pkg::S_Q_WALK || state_ff == psmx_pkg::S_LOAD) |-> !trie_we)
      else $error("trie written outside an insert");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == psmx_pkg::S_DONE) && (count_ff == '0))
      else $error("result raised outside the end of a search");

endmodule

`default_nettype wire

// ----- test/testbench.sv -----
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int VALUE_W    = psmx_pkg::VALUE_W;
   localparam int MAX_ITEMS  = psmx_pkg::MAX_ITEMS_DEF;
   localparam int KEY_BITS   = psmx_pkg::KEY_BITS_DEF;
   localparam int TRIE_NODES = psmx_pkg::TRIE_NODES_DEF;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               last;
   } element_type;

   typedef struct packed {
      logic [VALUE_W-1:0] max_xor;
      logic               overflow;
   } split_result_type;

   typedef enum int {
      FILL_WIDE,
      FILL_NARROW,
      FILL_ONEHOT,
      FILL_ECHO,
      FILL_EXTREME
   } fill_style_type;

   logic clock = 1'b0;
   logic reset;

   psmx_req_if req_chan ();
   psmx_rsp_if rsp_chan ();

   prefix_suffix_max_xor u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #10 clock = ~clock;

   element_type      element_queue[$];
   split_result_type owed_results[$];
   int               send_idle_pct;
   int               recv_stall_pct;
   int               error_count = 0;

   logic [VALUE_W-1:0] prefix_xor [0:MAX_ITEMS];
   int unsigned        trie_kid [0:TRIE_NODES-1][0:1];
   int unsigned        free_node = 1;
   int unsigned        loaded_count = 0;
   logic [VALUE_W-1:0] total_xor = '0;
   logic               too_many = 1'b0;

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      error_count++;
      if (error_count <= 100)
         $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
   endtask

   function automatic void trie_insert_key(logic [VALUE_W-1:0] key);
      int unsigned cur;
      int unsigned dir;
      cur = 0;
      for (int b = KEY_BITS - 1; b >= 0; b--) begin
         dir = key[b];
         if (trie_kid[cur][dir] == 0) begin
            if (free_node >= TRIE_NODES)
               return;
            trie_kid[free_node][0] = 0;
            trie_kid[free_node][1] = 0;
            trie_kid[cur][dir] = free_node;
            free_node++;
         end
         cur = trie_kid[cur][dir];
      end
   endfunction

   function automatic logic [VALUE_W-1:0] trie_best_xor(logic [VALUE_W-1:0] key);
      int unsigned        cur;
      int unsigned        want;
      logic [VALUE_W-1:0] acc;
      cur = 0;
      acc = '0;
      for (int b = KEY_BITS - 1; b >= 0; b--) begin
         want = key[b] ^ 1'b1;
         if (trie_kid[cur][want] != 0) begin
            cur = trie_kid[cur][want];
            acc[b] = 1'b1;
         end else if (trie_kid[cur][want ^ 1] != 0) begin
            cur = trie_kid[cur][want ^ 1];
         end else begin
            break;
         end
      end
      return acc;
   endfunction

   function automatic void absorb_element(element_type e);
      logic [VALUE_W-1:0] best;
      logic [VALUE_W-1:0] hit;
      split_result_type   r;
      if (loaded_count < MAX_ITEMS) begin
         total_xor = total_xor ^ e.value;
         loaded_count++;
         prefix_xor[loaded_count] = total_xor;
      end else begin
         too_many = 1'b1;
      end
      if (e.last) begin
         trie_kid[0][0] = 0;
         trie_kid[0][1] = 0;
         free_node = 1;
         best = '0;
         prefix_xor[0] = '0;
         trie_insert_key('0);
         for (int unsigned i = 1; i <= loaded_count + 1; i++) begin
            hit = trie_best_xor(total_xor ^ prefix_xor[i-1]);
            if (hit > best)
               best = hit;
            if (i <= loaded_count)
               trie_insert_key(prefix_xor[i]);
         end
         r.max_xor  = best;
         r.overflow = too_many;
         owed_results.push_back(r);
         loaded_count = 0;
         total_xor = '0;
         too_many = 1'b0;
      end
   endfunction

   always @(posedge clock) begin : driver
      element_type nxt;
      if (reset) begin
         req_chan.valid <= 1'b0;
         req_chan.value <= '0;
         req_chan.last  <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            absorb_element({req_chan.value, req_chan.last});
         if (!req_chan.valid || req_chan.ready) begin
            if (element_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               nxt = element_queue.pop_front();
               req_chan.valid <= 1'b1;
               req_chan.value <= nxt.value;
               req_chan.last  <= nxt.last;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      split_result_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (owed_results.size() == 0) begin
               report_mismatch("unowed result", {21'b0, rsp_chan.max_xor}, '0);
            end else begin
               want = owed_results.pop_front();
               if (rsp_chan.max_xor !== want.max_xor)
                  report_mismatch("max_xor", {21'b0, rsp_chan.max_xor}, {21'b0, want.max_xor});
               if (rsp_chan.overflow !== want.overflow)
                  report_mismatch("overflow", {63'b0, rsp_chan.overflow}, {63'b0, want.overflow});
            end
         end
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic queue_sequence(int len, fill_style_type style);
      element_type e;
      logic [63:0] raw;
      for (int k = 0; k < len; k++) begin
         raw = {$urandom(), $urandom()};
         case (style)
            FILL_WIDE:    e.value = raw[VALUE_W-1:0];
            FILL_NARROW:  e.value = VALUE_W'(raw[3:0]);
            FILL_ONEHOT:  e.value = VALUE_W'(1) << $urandom_range(VALUE_W - 1);
            FILL_ECHO: begin
               if (k != 0 && raw[63])
                  e.value = element_queue[$].value;
               else
                  e.value = raw[VALUE_W-1:0];
            end
            default:      e.value = raw[0] ? '1 : '0;
         endcase
         e.last = (k == len - 1);
         element_queue.push_back(e);
      end
   endtask

   task automatic drain();
      while (element_queue.size() != 0 || req_chan.valid)
         @(negedge clock);
      while (owed_results.size() != 0)
         @(negedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin : stimulus
      int queued;
      int len;
      reset          = 1'b1;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      element_queue.push_back({VALUE_W'(0), 1'b1});
      element_queue.push_back({{VALUE_W{1'b1}}, 1'b1});
      element_queue.push_back({{VALUE_W{1'b1}}, 1'b0});
      element_queue.push_back({{VALUE_W{1'b1}}, 1'b1});
      element_queue.push_back({VALUE_W'(1), 1'b0});
      element_queue.push_back({VALUE_W'(2), 1'b0});
      element_queue.push_back({VALUE_W'(4), 1'b0});
      element_queue.push_back({VALUE_W'(8), 1'b1});
      element_queue.push_back({VALUE_W'(1) << (VALUE_W - 1), 1'b0});
      element_queue.push_back({VALUE_W'(5), 1'b1});
      element_queue.push_back({VALUE_W'(0), 1'b0});
      element_queue.push_back({VALUE_W'(0), 1'b0});
      element_queue.push_back({VALUE_W'(0), 1'b1});
      drain();

      // overrun the buffer, with the last mark on an extra element
      queue_sequence(MAX_ITEMS + 2, FILL_ECHO);
      drain();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
            default: begin send_idle_pct = 36; recv_stall_pct = 36; end
         endcase
         queued = 0;
         while (queued < 240) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(64, 9) : $urandom_range(8, 1);
            queue_sequence(len, fill_style_type'($urandom_range(4)));
            queued += len;
         end
         drain();
      end

      repeat (500) @(posedge clock);
      if (error_count == 0 && owed_results.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   initial begin : watchdog
      #40_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

`default_nettype wire

// ----- files.f -----
src/psmx_pkg.sv
src/psmx_if.sv
src/prefix_suffix_max_xor.sv
test/testbench.sv
